// ===== rtl/bfcc_pkg.sv =====
// Shared types and constants for the BER frame completeness checker.
package bfcc_pkg;

	localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

	localparam int unsigned LEN_W     = 32;
	localparam int unsigned NEST_W    = 10;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 32;

	localparam logic [LEN_W-1:0]  MAX_CONTENT_RESET = 32'd5000000;
	localparam logic [NEST_W-1:0] MAX_NESTING_RESET = 10'd1000;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_CONTENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_NESTING = 1'b1;

	localparam logic [1:0] ST_COMPLETE   = 2'd0;
	localparam logic [1:0] ST_ERROR      = 2'd1;
	localparam logic [1:0] ST_INCOMPLETE = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [LEN_W-1:0] frame_length;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_content_length;
		logic [NEST_W-1:0] max_nesting;
	} cfg_t;

endpackage

// ===== rtl/bfcc_cfg_regs.sv =====
// Configuration registers: content length limit and nesting limit.
module bfcc_cfg_regs
	import bfcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_content_length <= MAX_CONTENT_RESET;
			cfg_q.max_nesting        <= MAX_NESTING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IDX_MAX_CONTENT: begin
					cfg_q.max_content_length <= cfg_data[LEN_W-1:0];
				end
				CFG_IDX_MAX_NESTING: begin
					cfg_q.max_nesting <= cfg_data[NEST_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/bfcc_parser.sv =====
// TLV parse state and per-byte next-state and result logic.
module bfcc_parser
	import bfcc_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output logic      res_valid,
	output out_item_t res
);

	localparam int unsigned LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

	typedef enum logic [2:0] {
		PH_START,
		PH_TAG_ZERO,
		PH_DEEP_PENDING,
		PH_TAG_MORE,
		PH_LEN_FIRST,
		PH_LEN_MORE,
		PH_CONTENT,
		PH_DISCARD
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [NEST_W:0]        depth_q, depth_d;
	logic                   cons_q, cons_d;
	logic [LEN_CNT_W-1:0]   left_q, left_d;
	logic [LEN_W-1:0]       acc_q, acc_d;
	logic                   ovf_q, ovf_d;
	logic [LEN_W-1:0]       remain_q, remain_d;
	logic [LEN_W-1:0]       count_q, count_d;

	logic [7:0]       b;
	logic             too_deep;
	logic             do_lf, do_begin, do_elem, done;
	logic [LEN_W-1:0] begin_n;

	assign b        = item.data_byte;
	assign too_deep = depth_q > {1'b0, cfg.max_nesting};

	always_comb begin
		phase_d  = phase_q;
		depth_d  = depth_q;
		cons_d   = cons_q;
		left_d   = left_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		remain_d = remain_q;
		count_d  = (count_q == '1) ? count_q : count_q + LEN_W'(1);
		do_lf    = 1'b0;
		do_begin = 1'b0;
		do_elem  = 1'b0;
		done     = 1'b0;
		begin_n  = '0;

		case (phase_q)
			PH_START: begin
				if (b == 8'h00) begin
					phase_d = PH_TAG_ZERO;
				end else if (too_deep) begin
					phase_d = PH_DEEP_PENDING;
				end else begin
					cons_d  = b[5];
					phase_d = (b[4:0] == 5'h1F) ? PH_TAG_MORE : PH_LEN_FIRST;
				end
			end
			PH_TAG_ZERO: begin
				if (b == 8'h00) begin
					if (depth_q == '0) begin
						phase_d = PH_DISCARD;
					end else begin
						depth_d = depth_q - (NEST_W+1)'(1);
						do_elem = 1'b1;
					end
				end else if (too_deep) begin
					phase_d = PH_DISCARD;
				end else begin
					cons_d = 1'b0;
					do_lf  = 1'b1;
				end
			end
			PH_DEEP_PENDING: begin
				phase_d = PH_DISCARD;
			end
			PH_TAG_MORE: begin
				if (!b[7]) begin
					phase_d = PH_LEN_FIRST;
				end
			end
			PH_LEN_FIRST: begin
				do_lf = 1'b1;
			end
			PH_LEN_MORE: begin
				if (acc_q[LEN_W-1:LEN_W-8] != 8'h00) begin
					ovf_d = 1'b1;
				end
				acc_d = {acc_q[LEN_W-9:0], b};
				if (left_q != '0) begin
					left_d = left_q - LEN_CNT_W'(1);
				end
				if (left_d == '0) begin
					if (ovf_d || (acc_d > cfg.max_content_length)) begin
						phase_d = PH_DISCARD;
					end else begin
						do_begin = 1'b1;
						begin_n  = acc_d;
					end
				end
			end
			PH_CONTENT: begin
				if (remain_q != '0) begin
					remain_d = remain_q - LEN_W'(1);
				end
				if (remain_d == '0) begin
					do_elem = 1'b1;
				end
			end
			default: begin
				phase_d = PH_DISCARD;
			end
		endcase

		// first length byte: short form, long form or indefinite
		if (do_lf) begin
			if (b == 8'h80) begin
				if (!cons_d) begin
					phase_d = PH_DISCARD;
				end else begin
					depth_d = depth_q + (NEST_W+1)'(1);
					phase_d = PH_START;
				end
			end else if (!b[7]) begin
				if ({24'h0, b} > cfg.max_content_length) begin
					phase_d = PH_DISCARD;
				end else begin
					do_begin = 1'b1;
					begin_n  = {24'h0, b};
				end
			end else if ((b == 8'hFF) || (b[6:0] > 7'(MAX_LENGTH_BYTES))) begin
				phase_d = PH_DISCARD;
			end else begin
				left_d  = LEN_CNT_W'(b[6:0]);
				acc_d   = '0;
				ovf_d   = 1'b0;
				phase_d = PH_LEN_MORE;
			end
		end

		if (do_begin) begin
			if (begin_n == '0) begin
				do_elem = 1'b1;
			end else begin
				remain_d = begin_n;
				phase_d  = PH_CONTENT;
			end
		end

		// element finished: frame ends at depth zero
		if (do_elem) begin
			if (depth_d == '0) begin
				done = 1'b1;
			end else begin
				phase_d = PH_START;
			end
		end
	end

	assign res_valid          = done || item.end_of_buffer;
	assign res.frame_length   = count_d;
	assign res.status         = done ? ST_COMPLETE :
	                            (phase_d == PH_DISCARD) ? ST_ERROR : ST_INCOMPLETE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			depth_q  <= '0;
			cons_q   <= 1'b0;
			left_q   <= '0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
			remain_q <= '0;
			count_q  <= '0;
		end else if (fire) begin
			if (res_valid) begin
				phase_q  <= PH_START;
				depth_q  <= '0;
				cons_q   <= 1'b0;
				left_q   <= '0;
				acc_q    <= '0;
				ovf_q    <= 1'b0;
				remain_q <= '0;
				count_q  <= '0;
			end else begin
				phase_q  <= phase_d;
				depth_q  <= depth_d;
				cons_q   <= cons_d;
				left_q   <= left_d;
				acc_q    <= acc_d;
				ovf_q    <= ovf_d;
				remain_q <= remain_d;
				count_q  <= count_d;
			end
		end
	end

endmodule

// ===== rtl/ber_frame_completeness_checker_top.sv =====
// Top level: input register, parser, configuration registers and result register.
// Each byte passes the input register and the parser; its result goes to the result register.
// Throughput: one byte per cycle unless in_stall is high; parser state updates per byte.
// A byte moves on whenever the result register is empty, being taken, or not needed.
// Reset (arst_n low) clears the parse state, empties both registers and loads
// max_content_length = 5000000 and max_nesting = 1000.
module ber_frame_completeness_checker_top
	import bfcc_pkg::*;
#(
	parameter int unsigned MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      adv;
	logic      res_valid;
	out_item_t res;
	out_item_t out_q;
	logic      out_valid_q;

	bfcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bfcc_parser #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// advance when the byte makes no result or the result slot frees up
	assign adv      = valid_s1 && (!res_valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/bfcc_checker.sv =====
// Port-level checks for the BER frame completeness checker, bound to the top level.
module bfcc_checker
	import bfcc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data,
	input logic      cfg_valid,
	input logic      cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result item changed or dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_COMPLETE || out_data.status == ST_ERROR ||
		               out_data.status == ST_INCOMPLETE))
		else $error("result status out of range");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frame_length != '0)
		else $error("result item counts no bytes");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("result or stall shown during reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind ber_frame_completeness_checker_top bfcc_checker u_bfcc_checker (.*);
